@@ sv/sepsc_pkg.sv @@
// Shared constants, types and helpers of the silhouette extreme-point scan.
`default_nettype none
package sepsc_pkg;

    // Default coordinate width of column and row fields.
    localparam int COORD_BITS_DEFAULT = 12;

    // Fixed widths of the configuration registers.
    localparam int MODE_W     = 2;
    localparam int DIM_W      = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 8;

    // Depth of the row-event queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Scan modes.
    localparam logic [MODE_W-1:0] MODE_HIP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KNEE = 2'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_MODE    = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_FIRST_ROW    = 3'd3,
        REG_STOP_ROW     = 3'd4,
        REG_COLUMN_LIMIT = 3'd5
    } reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0] RST_SCAN_MODE    = MODE_HIP;
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [ROW_W-1:0]  RST_FIRST_ROW    = 12'd0;
    localparam logic [DIM_W-1:0]  RST_STOP_ROW     = 13'd480;
    localparam logic [ROW_W-1:0]  RST_COLUMN_LIMIT = 12'd4095;

    // Configuration as seen by front and back.
    typedef struct packed {
        logic [MODE_W-1:0] scan_mode;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [ROW_W-1:0]  first_row;
        logic [DIM_W-1:0]  stop_row;
        logic [ROW_W-1:0]  column_limit;
    } cfg_t;

    // Width that holds both a coordinate result and a configured dimension.
    function automatic int val_width(input int coord_bits);
        return (coord_bits + 1 > DIM_W) ? coord_bits + 1 : DIM_W;
    endfunction

endpackage
`default_nettype wire

@@ sv/sepsc_front.sv @@
// Front part: tracks the per-row extreme column and emits one event per closed row.
`default_nettype none
module sepsc_front #(
    parameter int COORD_BITS = sepsc_pkg::COORD_BITS_DEFAULT
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            clear,
    input  wire sepsc_pkg::cfg_t           cfg,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [sepsc_pkg::PIX_W-1:0]    pixel_value,
    input  wire  [COORD_BITS-1:0]          column,
    input  wire  [COORD_BITS-1:0]          row,
    input  wire                            frame_end,
    input  wire                            q_full,
    output logic                           q_push,
    output logic [2*COORD_BITS+1:0]        q_data
);

    localparam int VAL_W = sepsc_pkg::val_width(COORD_BITS);

    logic [COORD_BITS-1:0] ext_col_reg, ext_col_next;
    logic                  has_fg_reg, has_fg_next;
    logic [VAL_W-1:0]      col_v, width_v;
    logic                  is_fg, better, row_close, accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Per-pixel extreme update and row-close detection.
    always_comb begin
        col_v   = VAL_W'(column);
        width_v = VAL_W'(cfg.image_width);
        is_fg   = (col_v < width_v) && (pixel_value != '0);
        if (cfg.scan_mode == sepsc_pkg::MODE_HIP) begin
            better = column < ext_col_reg;
        end else begin
            better = column > ext_col_reg;
        end
        ext_col_next = ext_col_reg;
        has_fg_next  = has_fg_reg;
        if (is_fg && (!has_fg_reg || better)) begin
            ext_col_next = column;
        end
        if (is_fg) begin
            has_fg_next = 1'b1;
        end
        row_close = frame_end || ((width_v != '0) && (col_v == width_v - VAL_W'(1)));
        q_push    = accept && row_close;
        q_data    = {frame_end, has_fg_next, row, ext_col_next};
    end

    // Row state: cleared at reset, when a row closes or when the scan restarts.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            ext_col_reg <= '0;
            has_fg_reg  <= 1'b0;
        end else if (accept) begin
            if (row_close) begin
                ext_col_reg <= '0;
                has_fg_reg  <= 1'b0;
            end else begin
                ext_col_reg <= ext_col_next;
                has_fg_reg  <= has_fg_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/sepsc_queue.sv @@
// Small register queue that carries row events from front to back.
`default_nettype none
module sepsc_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = sepsc_pkg::QUEUE_DEPTH
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  wire  [DATA_W-1:0] push_data,
    output logic              full,
    input  wire               pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Storage, written at the tail.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/sepsc_back.sv @@
// Back part: applies the mode's extreme-point rule per row and issues the frame result.
`default_nettype none
module sepsc_back #(
    parameter int COORD_BITS = sepsc_pkg::COORD_BITS_DEFAULT
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        restart,
    input  wire sepsc_pkg::cfg_t       cfg,
    input  wire                        q_not_empty,
    input  wire  [2*COORD_BITS+1:0]    q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [COORD_BITS:0]        point_x,
    output logic [COORD_BITS:0]        point_y,
    output logic                       point_found
);

    localparam int VAL_W = sepsc_pkg::val_width(COORD_BITS);
    localparam int OUT_W = COORD_BITS + 1;

    logic [VAL_W-1:0] best_col_reg, best_row_reg, tie_col_reg, tie_row_reg;
    logic             tie_valid_reg, run_active_reg, fin_reg, out_valid_reg;
    logic [OUT_W-1:0] point_x_reg, point_y_reg;
    logic             point_found_reg;

    logic [COORD_BITS-1:0] ev_x, ev_row;
    logic                  ev_had, ev_last;
    logic [VAL_W-1:0]      x_v, row_v, init_col, init_row;
    logic                  in_window, improves, ties, toe_take, out_free;
    logic [VAL_W:0]        row_sum;
    logic [VAL_W-1:0]      py_v;
    logic                  found;

    assign {ev_last, ev_had, ev_row, ev_x} = q_data;
    assign out_free    = !out_valid_reg || out_ready;
    assign q_pop       = q_not_empty && !fin_reg && !restart;
    assign out_valid   = out_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_found = point_found_reg;

    // Row rule decision and frame result from the held state.
    always_comb begin
        x_v       = VAL_W'(ev_x);
        row_v     = VAL_W'(ev_row);
        in_window = ev_had && (row_v >= VAL_W'(cfg.first_row))
                    && (row_v < VAL_W'(cfg.stop_row));
        if (cfg.scan_mode == sepsc_pkg::MODE_HIP) begin
            improves = x_v < best_col_reg;
        end else begin
            improves = x_v > best_col_reg;
        end
        ties     = run_active_reg && (x_v == best_col_reg);
        toe_take = (x_v <= VAL_W'(cfg.column_limit)) && (x_v < best_col_reg);
        if (cfg.scan_mode == sepsc_pkg::MODE_KNEE) begin
            init_col = '0;
            init_row = '0;
            found    = best_col_reg != '0;
        end else begin
            init_col = VAL_W'(cfg.image_width);
            init_row = VAL_W'(cfg.image_height);
            found    = best_col_reg != VAL_W'(cfg.image_width);
        end
        row_sum = {1'b0, tie_row_reg} + {1'b0, best_row_reg};
        if (tie_valid_reg && (tie_col_reg == best_col_reg)) begin
            py_v = row_sum[VAL_W:1];
        end else begin
            py_v = best_row_reg;
        end
    end

    // Output payload, taken when the frame result is issued.
    always_ff @(posedge aclk) begin
        if (fin_reg && out_free && !restart) begin
            point_x_reg     <= best_col_reg[OUT_W-1:0];
            point_y_reg     <= py_v[OUT_W-1:0];
            point_found_reg <= found;
        end
    end

    // Scan state, frame finish flag and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_col_reg   <= VAL_W'(sepsc_pkg::RST_IMAGE_WIDTH);
            best_row_reg   <= VAL_W'(sepsc_pkg::RST_IMAGE_HEIGHT);
            tie_col_reg    <= '0;
            tie_row_reg    <= '0;
            tie_valid_reg  <= 1'b0;
            run_active_reg <= 1'b0;
            fin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            // A result beat is raised when the frame finishes and dropped once taken.
            if (fin_reg && out_free && !restart) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            priority if (restart) begin
                best_col_reg   <= init_col;
                best_row_reg   <= init_row;
                tie_col_reg    <= '0;
                tie_row_reg    <= '0;
                tie_valid_reg  <= 1'b0;
                run_active_reg <= 1'b0;
                fin_reg        <= 1'b0;
            end else if (fin_reg) begin
                if (out_free) begin
                    best_col_reg   <= init_col;
                    best_row_reg   <= init_row;
                    tie_col_reg    <= '0;
                    tie_row_reg    <= '0;
                    tie_valid_reg  <= 1'b0;
                    run_active_reg <= 1'b0;
                    fin_reg        <= 1'b0;
                end
            end else if (q_pop) begin
                // Apply the mode rule to a closed row inside the window.
                if (in_window) begin
                    if ((cfg.scan_mode == sepsc_pkg::MODE_HIP)
                        || (cfg.scan_mode == sepsc_pkg::MODE_KNEE)) begin
                        if (improves) begin
                            best_col_reg   <= x_v;
                            best_row_reg   <= row_v;
                            run_active_reg <= 1'b1;
                        end else if (ties) begin
                            tie_col_reg   <= x_v;
                            tie_row_reg   <= row_v;
                            tie_valid_reg <= 1'b1;
                        end else begin
                            run_active_reg <= 1'b0;
                        end
                    end else if (toe_take) begin
                        best_col_reg <= x_v;
                        best_row_reg <= row_v;
                    end
                end
                fin_reg <= ev_last;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/silhouette_extreme_point_scan_core.sv @@
// Top level of the silhouette extreme-point scan: configuration registers and stream ports.
// Pixels of a binary silhouette enter in raster order on the s_ stream, one beat per clock
// while s_tready is high; the front keeps each row's first or last foreground column and
// hands one event per closed row to a four-entry queue, and the back applies the hip, knee
// or toe rule and sends one result beat on the m_ stream per frame. The frame_end beat
// reaches m_tvalid through a queue slot, fin_reg and out_valid_reg. The back takes no row
// event while it issues a result, so it drains the queue more slowly than one event per
// clock when frames end often. s_tready falls only when the queue fills: while the m_ side
// holds a result unaccepted, or when rows close and frames end on nearly every beat, as with
// very narrow images. A configuration write abandons the image in progress; the back reloads
// its scan state in the cycle after the write and after reset, and takes no row event then.
`default_nettype none
module silhouette_extreme_point_scan_core #(
    parameter int COORD_BITS = sepsc_pkg::COORD_BITS_DEFAULT,
    parameter int S_DATA_W   = ((sepsc_pkg::PIX_W + 2 * COORD_BITS + 7) / 8) * 8,
    parameter int M_DATA_W   = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // Configuration write channel.
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [sepsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [sepsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Pixel stream.
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [S_DATA_W-1:0]                s_tdata,  // pixel_value, column, row
    input  wire                                s_tlast,  // frame_end
    // Result stream.
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [M_DATA_W-1:0]                m_tdata,  // point_x, point_y
    output logic                               m_tuser   // point_found
);

    localparam int PIX_W  = sepsc_pkg::PIX_W;
    localparam int OUT_W  = COORD_BITS + 1;
    localparam int EV_W   = 2 * COORD_BITS + 2;

    sepsc_pkg::cfg_t    cfg_reg;
    logic               restart_reg;
    logic               cfg_we;
    logic               q_push, q_full, q_pop, q_not_empty;
    logic [EV_W-1:0]    q_push_data, q_pop_data;
    logic [OUT_W-1:0]   point_x, point_y;
    logic               point_found;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready
                       && (cfg_index <= sepsc_pkg::CFG_IDX_W'(sepsc_pkg::REG_COLUMN_LIMIT));

    // Configuration registers and the restart pulse for the back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_mode    <= sepsc_pkg::RST_SCAN_MODE;
            cfg_reg.image_width  <= sepsc_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height <= sepsc_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.first_row    <= sepsc_pkg::RST_FIRST_ROW;
            cfg_reg.stop_row     <= sepsc_pkg::RST_STOP_ROW;
            cfg_reg.column_limit <= sepsc_pkg::RST_COLUMN_LIMIT;
            restart_reg          <= 1'b1;
        end else begin
            restart_reg <= cfg_we;
            if (cfg_we) begin
                unique case (sepsc_pkg::reg_idx_t'(cfg_index))
                    sepsc_pkg::REG_SCAN_MODE: begin
                        cfg_reg.scan_mode <= cfg_data[sepsc_pkg::MODE_W-1:0];
                    end
                    sepsc_pkg::REG_IMAGE_WIDTH: begin
                        cfg_reg.image_width <= cfg_data[sepsc_pkg::DIM_W-1:0];
                    end
                    sepsc_pkg::REG_IMAGE_HEIGHT: begin
                        cfg_reg.image_height <= cfg_data[sepsc_pkg::DIM_W-1:0];
                    end
                    sepsc_pkg::REG_FIRST_ROW: begin
                        cfg_reg.first_row <= cfg_data[sepsc_pkg::ROW_W-1:0];
                    end
                    sepsc_pkg::REG_STOP_ROW: begin
                        cfg_reg.stop_row <= cfg_data[sepsc_pkg::DIM_W-1:0];
                    end
                    sepsc_pkg::REG_COLUMN_LIMIT: begin
                        cfg_reg.column_limit <= cfg_data[sepsc_pkg::ROW_W-1:0];
                    end
                    default: begin
                        cfg_reg <= cfg_reg;
                    end
                endcase
            end
        end
    end

    sepsc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (cfg_we),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pixel_value (s_tdata[PIX_W-1:0]),
        .column      (s_tdata[PIX_W+COORD_BITS-1:PIX_W]),
        .row         (s_tdata[PIX_W+2*COORD_BITS-1:PIX_W+COORD_BITS]),
        .frame_end   (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    sepsc_queue #(
        .DATA_W (EV_W),
        .DEPTH  (sepsc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    sepsc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (restart_reg),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_found (point_found)
    );

    // Result beat packing; the padding bits above the payload are zero.
    assign m_tdata = M_DATA_W'({point_y, point_x});
    assign m_tuser = point_found;

endmodule
`default_nettype wire

@@ sv/sepsc_checker.sv @@
// Port-level checker of the scan core and its bind to the top level.
`default_nettype none
module sepsc_checker #(
    parameter int M_DATA_W = 32
) (
    input wire                aclk,
    input wire                aresetn,
    input wire                cfg_valid,
    input wire                cfg_ready,
    input wire                s_tready,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [M_DATA_W-1:0] m_tdata,
    input wire                m_tuser
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // No result beat is pending right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The event queue is empty after reset, so pixels are taken at once.
    assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("pixel stream not ready after reset");

    // Configuration beats are never refused.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration beat refused");

endmodule

bind silhouette_extreme_point_scan_core sepsc_checker #(
    .M_DATA_W (M_DATA_W)
) u_sepsc_checker (.*);
`default_nettype wire

@@ tb/tb_silhouette_extreme_point_scan_core.sv @@
// Self-checking testbench for the silhouette extreme-point scan core.
`timescale 1ns / 1ps

module tb_silhouette_extreme_point_scan_core;
    import sepsc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int ITEM_TARGET  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int S_DATA_W     = 32;
    localparam int M_DATA_W     = 32;

    // Toe mode and the spare mode code that behaves like it.
    localparam logic [MODE_W-1:0] MODE_TOE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic             found;
    } scan_point_t;

    // Tracks the scan state and holds the extreme points still to come out.
    class silhouette_scoreboard;
        logic [MODE_W-1:0] scan_mode;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [ROW_W-1:0]  first_row;
        logic [DIM_W-1:0]  stop_row;
        logic [ROW_W-1:0]  column_limit;
        logic [ROW_W-1:0]  row_col;
        bit                row_fg;
        logic [DIM_W-1:0]  best_col;
        logic [DIM_W-1:0]  best_row;
        logic [DIM_W-1:0]  tie_col;
        logic [DIM_W-1:0]  tie_row;
        bit                tie_valid;
        bit                run_active;
        scan_point_t       expected_points[$];
        int                mismatches;

        function new();
            scan_mode    = RST_SCAN_MODE;
            image_width  = RST_IMAGE_WIDTH;
            image_height = RST_IMAGE_HEIGHT;
            first_row    = RST_FIRST_ROW;
            stop_row     = RST_STOP_ROW;
            column_limit = RST_COLUMN_LIMIT;
            mismatches   = 0;
            restart();
        endfunction

        // Fresh image: the initial point depends on the mode.
        function void restart();
            row_col = '0;
            row_fg  = 1'b0;
            if (scan_mode == MODE_KNEE) begin
                best_col = '0;
                best_row = '0;
            end else begin
                best_col = image_width;
                best_row = image_height;
            end
            tie_col    = '0;
            tie_row    = '0;
            tie_valid  = 1'b0;
            run_active = 1'b0;
        endfunction

        // Any register write drops the image in progress.
        function void config_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SCAN_MODE:    scan_mode = val[MODE_W-1:0];
                REG_IMAGE_WIDTH:  image_width = val;
                REG_IMAGE_HEIGHT: image_height = val;
                REG_FIRST_ROW:    first_row = val[ROW_W-1:0];
                REG_STOP_ROW:     stop_row = val;
                REG_COLUMN_LIMIT: column_limit = val[ROW_W-1:0];
                default:          return;
            endcase
            restart();
        endfunction

        // Apply the extreme-point rule of the mode to a finished row.
        function void close_row(logic [ROW_W-1:0] row);
            logic [ROW_W-1:0] x;
            bit               had;
            x       = row_col;
            had     = row_fg;
            row_fg  = 1'b0;
            row_col = '0;
            if (!had || row < first_row || {1'b0, row} >= stop_row)
                return;
            if (scan_mode == MODE_HIP || scan_mode == MODE_KNEE) begin
                if (scan_mode == MODE_HIP ? x < best_col : x > best_col) begin
                    best_col   = x;
                    best_row   = row;
                    run_active = 1'b1;
                end else if (run_active && x == best_col) begin
                    tie_col   = x;
                    tie_row   = row;
                    tie_valid = 1'b1;
                end else begin
                    run_active = 1'b0;
                end
            end else if (x <= column_limit && x < best_col) begin
                best_col = x;
                best_row = row;
            end
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic [ROW_W-1:0] col,
                                 logic [ROW_W-1:0] row, logic last);
            scan_point_t p;
            if (col < image_width && pix != 0) begin
                if (!row_fg) begin
                    row_col = col;
                    row_fg  = 1'b1;
                end else if (scan_mode == MODE_HIP ? col < row_col : col > row_col) begin
                    row_col = col;
                end
            end
            if (last || (image_width != 0 && col == image_width - 1))
                close_row(row);
            if (!last)
                return;
            p.x = best_col;
            p.found = (scan_mode == MODE_KNEE) ? (best_col != 0) : (best_col != image_width);
            if (tie_valid && tie_col == best_col)
                p.y = ({1'b0, tie_row} + {1'b0, best_row}) >> 1;
            else
                p.y = best_row;
            expected_points.push_back(p);
            restart();
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at %0t: %s", $time, msg);
        endfunction

        function void check_point(logic [DIM_W-1:0] x, logic [DIM_W-1:0] y, logic found);
            scan_point_t e;
            if (expected_points.size() == 0) begin
                complain($sformatf("point with none pending: x=%0d y=%0d found=%0d",
                                   x, y, found));
                return;
            end
            e = expected_points.pop_front();
            if (e.x !== x || e.y !== y || e.found !== found)
                complain($sformatf("expected x=%0d y=%0d found=%0d, got x=%0d y=%0d found=%0d",
                                   e.x, e.y, e.found, x, y, found));
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // pixel_value, column, row
    logic                  s_tlast;   // frame_end
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // point_x, point_y
    logic                  m_tuser;   // point_found

    silhouette_scoreboard sb;
    int  pixels_sent = 0;
    int  rx_hold = 0;
    bit  tx_jitter = 1'b1;
    bit  rx_jitter = 1'b1;
    int  idle_cycles = 0;

    silhouette_extreme_point_scan_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(negedge aclk);
            stall = (rx_hold != 0) ? rx_hold : (rx_jitter ? $urandom_range(0, 10) : 0);
            rx_hold = 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_point(m_tdata[DIM_W-1:0], m_tdata[2*DIM_W-1:DIM_W], m_tuser);
        end
    end

    // One pixel beat; valid stays high when the next beat follows at once.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [ROW_W-1:0] col,
                              input logic [ROW_W-1:0] row, input logic last);
        int gap;
        gap = tx_jitter ? $urandom_range(0, 10) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col, pix};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel(pix, col, row, last);
        pixels_sent++;
    endtask

    // Stop offering pixels and let every pending point and row event drain.
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.config_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random subset of registers, weighted toward small images and edge settings.
    task automatic configure_random();
        int                    i;
        int                    stop_guess;
        bit                    wrote;
        reg_idx_t              idx;
        logic [CFG_DATA_W-1:0] v;
        wrote = 1'b0;
        for (i = 0; i <= REG_COLUMN_LIMIT; i++) begin
            if ($urandom_range(0, 1) || (i == REG_COLUMN_LIMIT && !wrote)) begin
                idx = reg_idx_t'(i);
                case (idx)
                    REG_SCAN_MODE:
                        v = ($urandom_range(0, 7) == 0) ? MODE_UNUSED : $urandom_range(0, 2);
                    REG_IMAGE_WIDTH:
                        case ($urandom_range(0, 9))
                            0:       v = 1;
                            1:       v = 4096;
                            2:       v = 0;
                            3:       v = $urandom_range(4097, 8191);
                            4:       v = $urandom_range(13, 4095);
                            default: v = $urandom_range(2, 12);
                        endcase
                    REG_IMAGE_HEIGHT:
                        case ($urandom_range(0, 5))
                            0:       v = 4096;
                            1:       v = 1;
                            default: v = $urandom_range(1, 4096);
                        endcase
                    REG_FIRST_ROW:
                        case ($urandom_range(0, 7))
                            0:       v = 4095;
                            1:       v = $urandom_range(0, 4095);
                            default: v = $urandom_range(0, 6);
                        endcase
                    REG_STOP_ROW: begin
                        stop_guess = sb.first_row + $urandom_range(1, 6);
                        case ($urandom_range(0, 9))
                            0:       v = 0;
                            1:       v = 4096;
                            2:       v = sb.first_row;
                            3:       v = (sb.first_row == 0) ? 0 : sb.first_row - 1;
                            default: v = (stop_guess > 4096) ? 4096 : stop_guess;
                        endcase
                    end
                    default:
                        case ($urandom_range(0, 5))
                            0:       v = 0;
                            1:       v = 4095;
                            2:       v = $urandom_range(0, 4095);
                            default: v = $urandom_range(0, 12);
                        endcase
                endcase
                write_reg(idx, v);
                wrote = 1'b1;
            end
        end
    endtask

    // A frame of silhouette rows. Narrow images go in raster order; wider ones get
    // a few scattered pixels per row that end on the last column. The foreground
    // span drifts slowly so that rows often tie on their extreme column.
    task automatic send_frame(input bit complete);
        int               w, n_rows, per_row, cut, r, k, lo, hi, col_max;
        bit               raster, empty_row, fg, is_last;
        logic [ROW_W-1:0] row_id;
        logic [ROW_W-1:0] col;
        logic [PIX_W-1:0] pix;
        w       = sb.image_width;
        raster  = (w >= 1 && w <= 12);
        col_max = (w >= 1 && w <= 4096) ? w - 1 : 4095;
        n_rows  = $urandom_range(1, 6);
        if ($urandom_range(0, 7) == 0)
            row_id = $urandom;
        else
            row_id = sb.first_row - $urandom_range(0, 2);
        lo = $urandom_range(0, col_max);
        hi = $urandom_range(lo, col_max);
        for (r = 0; r < n_rows; r++) begin
            per_row   = raster ? w : $urandom_range(2, 8);
            cut       = per_row;
            if (complete && r == n_rows - 1 && $urandom_range(0, 5) == 0)
                cut = $urandom_range(1, per_row);
            empty_row = ($urandom_range(0, 5) == 0);
            for (k = 0; k < cut; k++) begin
                if (raster) begin
                    col = k;
                    fg  = (!empty_row && k >= lo && k <= hi) || $urandom_range(0, 15) == 0;
                end else if (k == per_row - 1) begin
                    col = col_max;
                    fg  = !empty_row && $urandom_range(0, 3) == 0;
                end else begin
                    case ($urandom_range(0, 7))
                        0:       col = $urandom;
                        1, 2:    col = lo;
                        3, 4:    col = hi;
                        default: col = $urandom_range(lo, hi);
                    endcase
                    fg = !empty_row && $urandom_range(0, 4) != 0;
                end
                pix     = fg ? $urandom_range(1, 255) : 0;
                is_last = complete && r == n_rows - 1 && k == cut - 1;
                send_pixel(pix, col, row_id, is_last);
            end
            row_id++;
            if ($urandom_range(0, 2) == 0)
                lo = lo + ($urandom_range(0, 1) ? 1 : -1);
            if ($urandom_range(0, 2) == 0)
                hi = hi + ($urandom_range(0, 1) ? 1 : -1);
            if (lo < 0)
                lo = 0;
            if (lo > col_max)
                lo = col_max;
            if (hi > col_max)
                hi = col_max;
            if (hi < lo)
                hi = lo;
        end
    endtask

    // Pixels with every field random, some carrying frame_end.
    task automatic send_stray_pixels();
        int n, k;
        n = $urandom_range(3, 20);
        for (k = 0; k < n; k++)
            send_pixel($urandom, $urandom, $urandom, k == n - 1 || $urandom_range(0, 15) == 0);
    endtask

    initial begin
        int phase;
        sb        = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SCAN_MODE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Hip mode on a 4-wide image: out-of-order foreground, a tie run,
        // a column past the row end and a frame ending on an empty row.
        write_reg(REG_SCAN_MODE, MODE_HIP);
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 3);
        write_reg(REG_FIRST_ROW, 0);
        write_reg(REG_STOP_ROW, 3);
        write_reg(REG_COLUMN_LIMIT, 4095);
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 2, 0, 0);
        send_pixel(1, 1, 0, 0);
        send_pixel(0, 3, 0, 0);
        send_pixel(128, 1, 1, 0);
        send_pixel(0, 3, 1, 0);
        send_pixel(200, 4095, 2, 0);
        send_pixel(0, 3, 2, 1);

        // Knee mode: a row whose rightmost pixel is column zero, then a tie run.
        drain_block();
        write_reg(REG_SCAN_MODE, MODE_KNEE);
        send_pixel(255, 0, 0, 0);
        send_pixel(0, 3, 0, 0);
        send_pixel(255, 3, 1, 0);
        send_pixel(255, 3, 2, 1);

        // Spare mode code acting as toe mode, at the largest sizes and rows.
        drain_block();
        write_reg(REG_SCAN_MODE, MODE_UNUSED);
        write_reg(REG_IMAGE_WIDTH, 4096);
        write_reg(REG_IMAGE_HEIGHT, 4096);
        write_reg(REG_FIRST_ROW, 4095);
        write_reg(REG_STOP_ROW, 4096);
        write_reg(REG_COLUMN_LIMIT, 0);
        send_pixel(255, 0, 4095, 0);
        send_pixel(0, 4095, 4095, 0);
        send_pixel(255, 4095, 4094, 1);

        // Inverted window: nothing is found.
        drain_block();
        write_reg(REG_STOP_ROW, 0);
        send_pixel(255, 5, 4095, 1);

        // Width zero: no column ends a row and every pixel is ignored.
        drain_block();
        write_reg(REG_SCAN_MODE, MODE_TOE);
        write_reg(REG_IMAGE_WIDTH, 0);
        send_pixel(255, 0, 0, 1);

        // Random phases of settings and frames; phase 2 holds the result side
        // off while pixels stream in back to back.
        phase = 0;
        while (pixels_sent < ITEM_TARGET) begin
            drain_block();
            configure_random();
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            if (phase == 2) begin
                write_reg(REG_IMAGE_WIDTH, 8);
                tx_jitter = 1'b0;
                rx_hold   = HOLD_CYCLES;
            end
            repeat ((phase == 2) ? 8 : $urandom_range(1, 5)) begin
                if ($urandom_range(0, 9) == 0)
                    send_stray_pixels();
                else
                    send_frame(1'b1);
            end
            // An unfinished image, dropped by the next register write.
            if ($urandom_range(0, 3) == 0)
                send_frame(1'b0);
            phase++;
        end

        drain_block();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sepsc_pkg.sv
sv/sepsc_front.sv
sv/sepsc_queue.sv
sv/sepsc_back.sv
sv/silhouette_extreme_point_scan_core.sv
sv/sepsc_checker.sv
tb/tb_silhouette_extreme_point_scan_core.sv
